@@ hdl/ttip_pkg.sv @@
// Package for the text to integer parser: parse phases, character codes,
// status and register codes, and the digit decoder.
// No dependencies.
package ttip_pkg;

    localparam int MAX_CHARS = 4096;
    localparam int POS_W = $clog2(MAX_CHARS + 1);
    localparam int VAL_W = 64;
    localparam int BASE_W = 6;

    typedef enum logic [2:0] {
        PH_SPACE  = 3'd0,
        PH_SIGNED = 3'd1,
        PH_ZERO   = 3'd2,
        PH_ZEROX  = 3'd3,
        PH_DIGITS = 3'd4,
        PH_DONE   = 3'd5
    } t_phase;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_NODIG = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic {
        CFG_RADIX  = 1'b0,
        CFG_SIGNED = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic              ok;
        logic [BASE_W-1:0] value;
    } t_digit;

    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UZ    = 8'h5A;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CASE_BIT = 8'h20;

    localparam logic [BASE_W-1:0] BASE_AUTO = 6'd0;
    localparam logic [BASE_W-1:0] BASE_OCT  = 6'd8;
    localparam logic [BASE_W-1:0] BASE_DEC  = 6'd10;
    localparam logic [BASE_W-1:0] BASE_HEX  = 6'd16;

    function automatic t_digit digit_of(input logic [7:0] c, input logic [BASE_W-1:0] b);
        t_digit     d;
        logic [7:0] u;
        u = c & ~CASE_BIT;
        d.ok = 1'b0;
        d.value = '0;
        if (c >= CH_ZERO && c <= CH_NINE) begin
            d.value = BASE_W'(c - CH_ZERO);
            d.ok = 1'b1;
        end else if (u >= CH_UA && u <= CH_UZ) begin
            d.value = BASE_W'(u - CH_UA) + BASE_W'(10);
            d.ok = 1'b1;
        end
        if (d.value >= b) begin
            d.ok = 1'b0;
        end
        return d;
    endfunction

endpackage

@@ hdl/text_to_integer_parser.sv @@
// Top level of the text to integer parser: input register, parse state
// update with a 64 by 6 multiply-add, and result register.
// Depends on ttip_pkg.

// The parser takes one character word per cycle, unless stalled, and gives
// one result word for each string, on the word marked last, once that word
// has passed the input and result registers. Each accumulator step is a 64-bit by
// 6-bit multiply-add with overflow detection. A new string may follow
// its last word directly. The input stalls only when a last word waits
// while an undelivered result is held. Consumed counts saturate at 4096.
module text_to_integer_parser
    import ttip_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic              i_cfg_index,
    input  logic [BASE_W-1:0] i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  logic [7:0]        i_char_in,
    input  logic              i_last,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output logic [VAL_W-1:0]  o_value,
    output logic [1:0]        o_status,
    output logic [POS_W-1:0]  o_consumed
);

    localparam logic [VAL_W-1:0] SMAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic [VAL_W-1:0] SMIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS);

    logic [BASE_W-1:0] r_radix;
    logic              r_signed;

    logic              r_in_valid;
    logic [7:0]        r_char;
    logic              r_last;

    t_phase            r_phase, n_phase;
    logic [VAL_W-1:0]  r_acc, n_acc;
    logic              r_neg, n_neg;
    logic              r_ovf, n_ovf;
    logic [BASE_W-1:0] r_base, n_base;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [POS_W-1:0]  r_end, n_end;
    logic              r_seen, n_seen;

    logic              r_out_valid;
    logic [VAL_W-1:0]  r_value, n_value;
    logic [1:0]        r_status, n_status;
    logic [POS_W-1:0]  r_consumed, n_consumed;

    logic              hold;
    logic              adv;
    logic              accept;
    logic              is_ws;
    logic              zero_start;
    logic [BASE_W-1:0] start_base;
    logic [BASE_W-1:0] take_base;
    logic              do_take;
    t_digit            dig;
    t_digit            hex_dig;
    logic [VAL_W+BASE_W:0] mac;
    logic [POS_W-1:0]  pos_inc;

    assign hold       = r_in_valid && r_last && r_out_valid && i_out_stall;
    assign adv        = r_in_valid && !hold;
    assign o_in_stall = hold;
    assign accept     = i_in_valid && !o_in_stall;

    assign is_ws      = (r_char == CH_SPACE) || (r_char >= CH_TAB && r_char <= CH_CR);
    assign zero_start = (r_char == CH_ZERO) && (r_radix == BASE_AUTO || r_radix == BASE_HEX);
    assign start_base = (r_radix == BASE_AUTO) ? BASE_DEC : r_radix;
    assign pos_inc    = (r_pos < POS_MAX) ? r_pos + POS_W'(1) : POS_MAX;
    assign hex_dig    = digit_of(r_char, BASE_HEX);

    always_comb begin
        case (r_phase)
            PH_SPACE, PH_SIGNED: take_base = start_base;
            PH_ZEROX:            take_base = BASE_HEX;
            default:             take_base = r_base;
        endcase
    end

    assign dig = digit_of(r_char, take_base);
    assign mac = (VAL_W+BASE_W+1)'(r_acc) * (VAL_W+BASE_W+1)'(take_base)
               + (VAL_W+BASE_W+1)'(dig.value);

    always_comb begin
        n_phase = r_phase;
        n_acc   = r_acc;
        n_neg   = r_neg;
        n_ovf   = r_ovf;
        n_base  = r_base;
        n_end   = r_end;
        n_seen  = r_seen;
        n_pos   = pos_inc;
        do_take = 1'b0;
        case (r_phase)
            PH_SPACE, PH_SIGNED: begin
                if (r_phase == PH_SPACE && is_ws) begin
                    n_phase = r_phase;
                end else if (r_phase == PH_SPACE &&
                             (r_char == CH_PLUS || r_char == CH_MINUS)) begin
                    n_neg   = (r_char == CH_MINUS);
                    n_phase = PH_SIGNED;
                end else if (zero_start) begin
                    n_base  = (r_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
                    n_acc   = '0;
                    n_seen  = 1'b1;
                    n_end   = pos_inc;
                    n_phase = PH_ZERO;
                end else begin
                    n_base  = start_base;
                    do_take = 1'b1;
                end
            end
            PH_ZERO: begin
                if ((r_char & ~CASE_BIT) == CH_UX) begin
                    n_phase = PH_ZEROX;
                end else begin
                    do_take = 1'b1;
                end
            end
            PH_ZEROX: begin
                if (hex_dig.ok) begin
                    n_base  = BASE_HEX;
                    do_take = 1'b1;
                end else begin
                    n_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                do_take = 1'b1;
            end
            default: begin
                n_phase = r_phase;
            end
        endcase
        if (do_take) begin
            if (!dig.ok) begin
                n_phase = PH_DONE;
            end else begin
                if (!r_ovf) begin
                    if (mac[VAL_W+BASE_W:VAL_W] != '0) begin
                        n_ovf = 1'b1;
                    end else begin
                        n_acc = mac[VAL_W-1:0];
                    end
                end
                n_seen  = 1'b1;
                n_end   = pos_inc;
                n_phase = PH_DIGITS;
            end
        end
    end

    always_comb begin
        n_value    = '0;
        n_status   = ST_OK;
        n_consumed = '0;
        if (!n_seen) begin
            n_status = ST_NODIG;
        end else begin
            n_consumed = n_end;
            if (r_signed) begin
                if (!n_ovf && !n_neg && !n_acc[VAL_W-1]) begin
                    n_value = n_acc;
                end else if (!n_ovf && n_neg && (!n_acc[VAL_W-1] || n_acc == SMIN)) begin
                    n_value = '0 - n_acc;
                end else begin
                    n_value  = n_neg ? SMIN : SMAX;
                    n_status = ST_RANGE;
                end
            end else if (n_ovf) begin
                n_value  = '1;
                n_status = ST_RANGE;
            end else begin
                n_value = n_neg ? '0 - n_acc : n_acc;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radix  <= BASE_DEC;
            r_signed <= 1'b1;
        end else if (i_cfg_we) begin
            case (t_cfg_index'(i_cfg_index))
                CFG_RADIX:  r_radix  <= i_cfg_data;
                CFG_SIGNED: r_signed <= i_cfg_data[0];
                default:    r_radix  <= r_radix;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (accept) begin
            r_in_valid <= 1'b1;
        end else if (adv) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_char <= i_char_in;
            r_last <= i_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (adv && r_last)) begin
            r_phase <= PH_SPACE;
            r_acc   <= '0;
            r_neg   <= 1'b0;
            r_ovf   <= 1'b0;
            r_base  <= '0;
            r_pos   <= '0;
            r_end   <= '0;
            r_seen  <= 1'b0;
        end else if (adv) begin
            r_phase <= n_phase;
            r_acc   <= n_acc;
            r_neg   <= n_neg;
            r_ovf   <= n_ovf;
            r_base  <= n_base;
            r_pos   <= n_pos;
            r_end   <= n_end;
            r_seen  <= n_seen;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv && r_last) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv && r_last) begin
            r_value    <= n_value;
            r_status   <= n_status;
            r_consumed <= n_consumed;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_value     = r_value;
    assign o_status    = r_status;
    assign o_consumed  = r_consumed;

endmodule

@@ test/tb_text_to_integer_parser.sv @@
// Self-checking testbench for text_to_integer_parser: directed and random strings
// are streamed in, and each result word is checked against a built-in predictor.
// Depends on ttip_pkg and text_to_integer_parser.
`timescale 1ns / 1ps

module tb_text_to_integer_parser;
    import ttip_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PRINT_LIMIT = 40;
    localparam logic [VAL_W-1:0] SIGNED_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [VAL_W-1:0] SIGNED_MIN = 64'h8000_0000_0000_0000;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_word;

    typedef struct {
        logic [VAL_W-1:0] value;
        t_status          status;
        logic [POS_W-1:0] consumed;
    } t_parse_result;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              cfg_we = 1'b0;
    t_cfg_index        cfg_index = CFG_RADIX;
    logic [BASE_W-1:0] cfg_data = '0;
    logic              in_valid = 1'b0;
    logic              in_stall;
    logic [7:0]        char_in = '0;
    logic              last_in = 1'b0;
    logic              out_valid;
    logic              out_stall = 1'b0;
    logic [VAL_W-1:0]  value_out;
    logic [1:0]        status_out;
    logic [POS_W-1:0]  consumed_out;

    t_word         char_queue[$];
    t_parse_result expected_results[$];
    t_word         next_word;
    int            words_queued = 0;
    int            words_accepted = 0;
    int            error_count = 0;
    int            idle_pct = 0;
    int            send_gap = 0;
    int            stall_left = 0;
    int            quiet_cycles = 0;

    logic [BASE_W-1:0] cur_radix = BASE_DEC;
    logic              cur_signed = 1'b1;

    t_phase            p_phase = PH_SPACE;
    logic [VAL_W-1:0]  p_acc = '0;
    logic              p_neg = 1'b0;
    logic              p_ovf = 1'b0;
    logic [BASE_W-1:0] p_base = '0;
    logic [POS_W-1:0]  p_pos = '0;
    logic [POS_W-1:0]  p_end = '0;
    logic              p_seen = 1'b0;

    text_to_integer_parser u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_cfg_we    (cfg_we),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_char_in   (char_in),
        .i_last      (last_in),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_value     (value_out),
        .o_status    (status_out),
        .o_consumed  (consumed_out)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic int digit_value(input logic [7:0] c, input logic [BASE_W-1:0] b);
        logic [7:0] up;
        int         v;
        up = c & ~CASE_BIT;
        if (c >= "0" && c <= "9") begin
            v = int'(c) - int'("0");
        end else if (up >= "A" && up <= "Z") begin
            v = int'(up) - int'("A") + 10;
        end else begin
            return -1;
        end
        return (v < int'(b)) ? v : -1;
    endfunction

    function automatic logic [POS_W-1:0] next_position();
        return (p_pos < MAX_CHARS) ? p_pos + 1'b1 : POS_W'(MAX_CHARS);
    endfunction

    task automatic clear_parse_state();
        p_phase = PH_SPACE;
        p_acc = '0;
        p_neg = 1'b0;
        p_ovf = 1'b0;
        p_base = '0;
        p_pos = '0;
        p_end = '0;
        p_seen = 1'b0;
    endtask

    task automatic accept_digit(input logic [7:0] c);
        int          v;
        logic [71:0] wide;
        v = digit_value(c, p_base);
        if (v < 0) begin
            p_phase = PH_DONE;
            return;
        end
        if (!p_ovf && p_base != 0) begin
            wide = 72'(p_acc) * 72'(p_base) + 72'(v);
            if (wide[71:64] != 0) begin
                p_ovf = 1'b1;
            end else begin
                p_acc = wide[63:0];
            end
        end
        p_seen = 1'b1;
        p_end = next_position();
        p_phase = PH_DIGITS;
    endtask

    task automatic start_number(input logic [7:0] c);
        if (c == CH_ZERO && (cur_radix == BASE_AUTO || cur_radix == BASE_HEX)) begin
            p_base = (cur_radix == BASE_AUTO) ? BASE_OCT : BASE_HEX;
            p_acc = '0;
            p_seen = 1'b1;
            p_end = next_position();
            p_phase = PH_ZERO;
        end else begin
            p_base = (cur_radix == BASE_AUTO) ? BASE_DEC : cur_radix;
            accept_digit(c);
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic last);
        t_parse_result r;
        case (p_phase)
            PH_SPACE: begin
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR)) begin
                end else if (c == CH_PLUS || c == CH_MINUS) begin
                    p_neg = (c == CH_MINUS);
                    p_phase = PH_SIGNED;
                end else begin
                    start_number(c);
                end
            end
            PH_SIGNED: begin
                start_number(c);
            end
            PH_ZERO: begin
                if ((c & ~CASE_BIT) == CH_UX) begin
                    p_phase = PH_ZEROX;
                end else begin
                    accept_digit(c);
                end
            end
            PH_ZEROX: begin
                if (digit_value(c, BASE_HEX) >= 0) begin
                    p_base = BASE_HEX;
                    accept_digit(c);
                end else begin
                    p_phase = PH_DONE;
                end
            end
            PH_DIGITS: begin
                accept_digit(c);
            end
            default: begin
            end
        endcase
        p_pos = next_position();
        if (!last) begin
            return;
        end
        r.value = '0;
        r.status = ST_OK;
        r.consumed = '0;
        if (!p_seen) begin
            r.status = ST_NODIG;
        end else begin
            r.consumed = p_end;
            if (cur_signed) begin
                if (!p_ovf && !p_neg && p_acc <= SIGNED_MAX) begin
                    r.value = p_acc;
                end else if (!p_ovf && p_neg && p_acc <= SIGNED_MIN) begin
                    r.value = '0 - p_acc;
                end else begin
                    r.value = p_neg ? SIGNED_MIN : SIGNED_MAX;
                    r.status = ST_RANGE;
                end
            end else if (p_ovf) begin
                r.value = '1;
                r.status = ST_RANGE;
            end else begin
                r.value = p_neg ? '0 - p_acc : p_acc;
            end
        end
        expected_results.push_back(r);
        clear_parse_state();
    endtask

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        if (error_count < PRINT_LIMIT) begin
            $display("%0t: %s mismatch: got %0h, expected %0h", $realtime, what, got, want);
        end
        error_count++;
    endtask

    task automatic check_result();
        t_parse_result want;
        if (expected_results.size() == 0) begin
            report_mismatch("unexpected result word", value_out, '0);
            return;
        end
        want = expected_results.pop_front();
        if (value_out !== want.value) begin
            report_mismatch("value", value_out, want.value);
        end
        if (status_out !== want.status) begin
            report_mismatch("status", 64'(status_out), 64'(want.status));
        end
        if (consumed_out !== want.consumed) begin
            report_mismatch("consumed", 64'(consumed_out), 64'(want.consumed));
        end
    endtask

    // Driver: a stalled word is held; otherwise the next word or a gap is chosen.
    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
            clear_parse_state();
        end else begin
            if (in_valid && !in_stall) begin
                parse_char(char_in, last_in);
                words_accepted++;
            end
            if (!(in_valid && in_stall)) begin
                if (send_gap > 0) begin
                    send_gap--;
                    in_valid <= 1'b0;
                end else if (char_queue.size() == 0) begin
                    in_valid <= 1'b0;
                end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                    send_gap = $urandom_range(0, 4);
                    in_valid <= 1'b0;
                end else begin
                    next_word = char_queue.pop_front();
                    in_valid <= 1'b1;
                    char_in <= next_word.ch;
                    last_in <= next_word.last;
                end
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            if (out_valid && !out_stall) begin
                check_result();
            end
            if (stall_left > 0) begin
                stall_left--;
                out_stall <= 1'b1;
            end else if (idle_pct > 0 && $urandom_range(0, 99) < idle_pct) begin
                stall_left = $urandom_range(0, 4);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("text_to_integer_parser regression: fail");
            $finish;
        end
    end

    task automatic queue_bytes(input logic [7:0] text[$]);
        t_word w;
        foreach (text[k]) begin
            w.ch = text[k];
            w.last = (k == text.size() - 1);
            char_queue.push_back(w);
            words_queued++;
        end
    endtask

    task automatic queue_text(input string s);
        logic [7:0] text[$];
        for (int k = 0; k < s.len(); k++) begin
            text.push_back(s[k]);
        end
        queue_bytes(text);
    endtask

    function automatic logic [7:0] space_symbol();
        int k;
        k = $urandom_range(0, 5);
        return (k == 5) ? CH_SPACE : CH_TAB + 8'(k);
    endfunction

    function automatic logic [7:0] digit_symbol(input int d);
        logic [7:0] sym;
        if (d < 10) begin
            return 8'(int'("0") + d);
        end
        sym = 8'(int'("a") + d - 10);
        return $urandom_range(0, 1) ? (sym & ~CASE_BIT) : sym;
    endfunction

    task automatic queue_random_number(input logic [BASE_W-1:0] rdx);
        logic [7:0] text[$];
        int         eff, lim, n_digits, pick, d;
        if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 4)) text.push_back(space_symbol());
        end
        pick = $urandom_range(0, 3);
        if (pick == 0) begin
            text.push_back(CH_MINUS);
        end else if (pick == 1) begin
            text.push_back(CH_PLUS);
        end
        eff = (rdx == BASE_AUTO) ? 10 : int'(rdx);
        if (rdx == BASE_AUTO || rdx == BASE_HEX) begin
            pick = $urandom_range(0, 3);
            if (pick == 0) begin
                text.push_back(CH_ZERO);
                text.push_back($urandom_range(0, 1) ? CH_UX : (CH_UX | CASE_BIT));
                eff = 16;
            end else if (pick == 1 && rdx == BASE_AUTO) begin
                text.push_back(CH_ZERO);
                eff = 8;
            end
        end
        lim = (eff > 36) ? 36 : eff;
        n_digits = ($urandom_range(0, 3) == 0) ? $urandom_range(12, 30) : $urandom_range(1, 8);
        repeat (n_digits) begin
            d = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 35) : $urandom_range(0, lim - 1);
            text.push_back(digit_symbol(d));
        end
        if ($urandom_range(0, 2) == 0) begin
            repeat ($urandom_range(1, 3)) text.push_back(8'($urandom_range(0, 255)));
        end
        queue_bytes(text);
    endtask

    task automatic queue_noise();
        logic [7:0] text[$];
        repeat ($urandom_range(1, 6)) text.push_back(8'($urandom_range(0, 255)));
        queue_bytes(text);
    endtask

    // Waits until every queued word is taken and every result word has come.
    task automatic wait_drained();
        while (words_accepted != words_queued || expected_results.size() != 0) begin
            @(posedge clk);
        end
        repeat (4) @(posedge clk);
    endtask

    task automatic write_config(input logic [BASE_W-1:0] rdx, input logic sgn);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= CFG_RADIX;
        cfg_data <= rdx;
        @(posedge clk);
        cfg_index <= CFG_SIGNED;
        cfg_data <= {5'($urandom_range(0, 31)), sgn};
        @(posedge clk);
        cfg_we <= 1'b0;
        cur_radix = rdx;
        cur_signed = sgn;
    endtask

    initial begin
        logic [7:0]        text[$];
        logic [BASE_W-1:0] radix_list[12];
        int                pct_list[12];
        int                target;

        radix_list = '{6'd10, 6'd0, 6'd16, 6'd0, 6'd2, 6'd8, 6'd36, 6'd63, 6'd1, 6'd0,
                       6'd7, 6'd10};
        pct_list = '{20, 0, 35, 10, 25, 15, 30, 5, 20, 40, 15, 0};
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        idle_pct = 20;
        text = {8'h09, 8'h0B, 8'h0C, 8'h0D, 8'h0A, CH_SPACE, CH_MINUS, "1", "2", "3"};
        queue_bytes(text);
        queue_text("+42");
        queue_text("x");
        queue_text("-");
        queue_text("+ 5");
        queue_text("9223372036854775807");
        queue_text("-9223372036854775808");
        queue_text("9223372036854775808");
        queue_text("-9223372036854775809");
        queue_text("123abc");
        text = {8'hA0, "5"};
        queue_bytes(text);
        text = {"7", 8'h80, "1", 8'hFF};
        queue_bytes(text);
        wait_drained();

        write_config(BASE_AUTO, 1'b1);
        queue_text("0x1fF");
        queue_text("0X");
        queue_text("0xg");
        queue_text("0777");
        queue_text("08");
        queue_text("-0x10");
        queue_text("0");
        queue_text("12");
        wait_drained();

        write_config(BASE_HEX, 1'b0);
        queue_text("0x");
        queue_text("0xAbC");
        queue_text("ff");
        queue_text("0x0xx");
        queue_text("-1");
        queue_text("FFFFFFFFFFFFFFFF");
        queue_text("10000000000000000");
        wait_drained();

        write_config(BASE_AUTO, 1'b0);
        queue_text("-1");
        queue_text("18446744073709551615");
        queue_text("18446744073709551616");
        queue_text("-0");
        wait_drained();

        write_config(6'd1, 1'b1);
        queue_text("000");
        queue_text("01");
        queue_text("1");
        wait_drained();

        write_config(6'd36, 1'b1);
        queue_text("zZ");
        queue_text("-Zz9");
        queue_text("zzzzzzzzzzzzzz");
        wait_drained();

        write_config(6'd63, 1'b0);
        queue_text("zz");
        queue_text("Z0");
        queue_text("zzzzzzzzzzz");
        wait_drained();

        for (int ph = 0; ph < 12; ph++) begin
            write_config(radix_list[ph], 1'($urandom_range(0, 1)));
            idle_pct = pct_list[ph];
            target = words_queued + 125;
            while (words_queued < target) begin
                if ($urandom_range(0, 6) == 0) begin
                    queue_noise();
                end else begin
                    queue_random_number(cur_radix);
                end
            end
            wait_drained();
        end

        repeat (10) @(posedge clk);
        if (error_count == 0) begin
            $display("text_to_integer_parser regression: pass");
        end else begin
            $display("text_to_integer_parser regression: fail");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
hdl/ttip_pkg.sv
hdl/text_to_integer_parser.sv
test/tb_text_to_integer_parser.sv
